FILE: hdl/iredc_pkg.sv
package iredc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int PIN_W = 3;
    localparam int BAUD_W = 22;
    localparam int CFG_IDX_W = 2;

    localparam int COUNT_BITS_DEF = 32;
    localparam int DURATION_BITS_DEF = 24;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PIN_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAUD_RATE = 2'd1;

    localparam logic [PIN_W-1:0] PIN_RESET = 3'd1;
    localparam logic [BAUD_W-1:0] BAUD_RESET = 22'd9600;

    // count * 1000000 / (baud * 32) equals count * 31250 / baud exactly,
    // since 1000000 is a multiple of 32.
    localparam int MULT_K_W = 15;
    localparam logic [MULT_K_W-1:0] MULT_K = 15'd31250;

    typedef struct packed {
        logic accept;
        logic mul;
        logic check;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic change;
        logic ovf;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/iredc_in_if.sv
interface iredc_in_if import iredc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_byte;

    modport source (output valid, output sample_byte, input ready);
    modport sink (input valid, input sample_byte, output ready);
endinterface

FILE: hdl/iredc_out_if.sv
interface iredc_out_if import iredc_pkg::*; #(
    parameter int DW = DURATION_BITS_DEF
);
    logic          valid;
    logic          ready;
    logic [DW-1:0] duration_us;
    logic          is_pulse;

    modport source (output valid, output duration_us, output is_pulse, input ready);
    modport sink (input valid, input duration_us, input is_pulse, output ready);
endinterface

FILE: hdl/ir_edge_duration_capture.sv
// Channel   Dir  Payload                              Handshake
// i_in      in   sample_byte[7:0]                     valid / ready
// o_out     out  duration_us[DURATION_BITS-1:0],      valid / ready
//                is_pulse
//
// A sample with an unchanged level is accepted without leaving idle. A
// sample that ends a level passes accept, multiply, range check, the
// divider, which makes one quotient bit per cycle, and output load; an
// out-of-range result skips the divider. The output register lets a new
// sample in while a result waits; a stalled output holds the load stage.
// Reset is synchronous, active low, and clears the level and the counter.
module ir_edge_duration_capture import iredc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    iredc_in_if.sink             i_in,
    iredc_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BAUD_W-1:0]    i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    iredc_ctrl #(
        .DURATION_BITS(DURATION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    iredc_dp #(
        .COUNT_BITS    (COUNT_BITS),
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sample_byte (i_in.sample_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_duration_us (o_out.duration_us),
        .o_is_pulse    (o_out.is_pulse)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && w_status.change) |=> !i_in.ready)
        else $error("sample accepted while a duration is in progress");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_status.out_free)
        else $error("result register overwritten before transaction completed");

    a_no_divide_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !(w_cmd.div_step || w_cmd.mul || w_cmd.check))
        else $error("datapath busy while input is ready");
`endif

endmodule

FILE: hdl/iredc_ctrl.sv
module iredc_ctrl import iredc_pkg::*; #(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int ITER_W = $clog2(DURATION_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_LOAD
    } t_state;

    t_state            r_state;
    logic [ITER_W-1:0] r_iter;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.accept = i_in_valid;
            S_MUL:   o_cmd.mul = 1'b1;
            S_CHECK: o_cmd.check = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_LOAD:  o_cmd.load_out = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_status.change) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_iter <= ITER_W'(DURATION_BITS - 1);
                    if (i_status.ovf) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_iter == '0) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_iter <= r_iter - 1'b1;
                    end
                end
                S_LOAD: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/iredc_dp.sv
module iredc_dp import iredc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [SAMPLE_W-1:0]      i_sample_byte,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [BAUD_W-1:0]        i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [DURATION_BITS-1:0] o_duration_us,
    output logic                     o_is_pulse
);

    localparam int PROD_W = COUNT_BITS + MULT_K_W;
    localparam int CMP_W = (PROD_W > BAUD_W + DURATION_BITS) ? PROD_W
                                                             : BAUD_W + DURATION_BITS;

    logic [PIN_W-1:0]         r_pin;
    logic [BAUD_W-1:0]        r_baud;
    logic                     r_last_level;
    logic                     r_level_known;
    logic [COUNT_BITS-1:0]    r_count;
    logic [COUNT_BITS-1:0]    r_cap;
    logic [PROD_W-1:0]        r_mult;
    logic [BAUD_W-1:0]        r_rem;
    logic [DURATION_BITS-1:0] r_quo;
    logic                     r_out_valid;
    logic [DURATION_BITS-1:0] r_dur;
    logic                     r_pulse;

    logic                     w_level;
    logic [COUNT_BITS-1:0]    n_count;
    logic [CMP_W-1:0]         w_limit;
    logic [PROD_W-1:0]        w_high;
    logic [BAUD_W:0]          w_rem_sh;
    logic                     w_fits;

    assign w_level = i_sample_byte[r_pin];
    assign n_count = (r_count == '1) ? r_count : r_count + 1'b1;

    // The quotient overflows the output exactly when the dividend reaches
    // baud shifted up by the output width; a zero baud rate lands here too.
    assign w_limit = CMP_W'(r_baud) << DURATION_BITS;
    assign w_high = r_mult >> DURATION_BITS;
    assign w_rem_sh = {r_rem, r_quo[DURATION_BITS-1]};
    assign w_fits = (w_rem_sh >= {1'b0, r_baud});

    assign o_status.change = !r_level_known || (w_level != r_last_level);
    assign o_status.ovf = (CMP_W'(r_mult) >= w_limit);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_duration_us = r_dur;
    assign o_is_pulse = r_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin <= PIN_RESET;
            r_baud <= BAUD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PIN_SELECT: r_pin <= i_cfg_data[PIN_W-1:0];
                REG_BAUD_RATE:  r_baud <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_level_known <= 1'b0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (o_status.change) begin
                    r_last_level <= w_level;
                    r_level_known <= 1'b1;
                    r_count <= '0;
                end else begin
                    r_count <= n_count;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cap <= n_count;
        end
        if (i_cmd.mul) begin
            r_mult <= PROD_W'(r_cap) * PROD_W'(MULT_K);
        end
        // Restoring division, one quotient bit per step; the dividend's low
        // bits shift out of r_quo as the quotient bits shift in.
        if (i_cmd.check) begin
            if (o_status.ovf) begin
                r_quo <= '1;
            end else begin
                r_rem <= w_high[BAUD_W-1:0];
                r_quo <= r_mult[DURATION_BITS-1:0];
            end
        end else if (i_cmd.div_step) begin
            if (w_fits) begin
                r_rem <= BAUD_W'(w_rem_sh - {1'b0, r_baud});
            end else begin
                r_rem <= w_rem_sh[BAUD_W-1:0];
            end
            r_quo <= {r_quo[DURATION_BITS-2:0], w_fits};
        end
        if (i_cmd.load_out) begin
            r_dur <= r_quo;
            r_pulse <= r_last_level;
        end
    end

endmodule

FILE: tb/ir_edge_duration_capture_tb.sv
`timescale 1ns / 1ps

module ir_edge_duration_capture_tb;
    import iredc_pkg::*;

    localparam int DUR_W = DURATION_BITS_DEF;
    localparam int CNT_W = COUNT_BITS_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 4;
    localparam int CALM_ITEMS = 30;
    localparam int CALM_PHASE = 3;
    localparam int RANDOM_PHASES = 8;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [DUR_W-1:0] duration_us;
        logic             is_pulse;
    } t_span;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BAUD_W-1:0]    cfg_data;
    logic                 calm;

    iredc_in_if                 in_if ();
    iredc_out_if #(.DW(DUR_W))  out_if ();

    ir_edge_duration_capture u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow of the block: its registers and its level tracking state.
    logic [PIN_W-1:0]  pin_now;
    logic [BAUD_W-1:0] baud_now;
    logic              held_level;
    logic              level_seen;
    logic [CNT_W-1:0]  run_len;

    logic [SAMPLE_W-1:0] samples_todo[$];
    t_span               spans_due[$];
    t_span               want;
    int                  mismatches;
    int                  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [DUR_W-1:0] us_from_samples(input logic [CNT_W-1:0] n,
                                                         input logic [BAUD_W-1:0] b);
        longint unsigned q;
        // A zero baud rate makes the block's range check clamp the duration to all ones.
        if (b == '0) begin
            return '1;
        end
        q = (64'(n) * 64'd1000000) / (64'(b) * 64'd32);
        if (q > 64'((1 << DUR_W) - 1)) begin
            return '1;
        end
        return q[DUR_W-1:0];
    endfunction

    task automatic track_level(input logic [SAMPLE_W-1:0] smp);
        logic  level;
        t_span span;
        level = smp[pin_now];
        if (run_len != '1) begin
            run_len = run_len + 1'b1;
        end
        if (level_seen && level == held_level) begin
            return;
        end
        span.duration_us = us_from_samples(run_len, baud_now);
        span.is_pulse = level;
        spans_due.push_back(span);
        held_level = level;
        level_seen = 1'b1;
        run_len = '0;
    endtask

    // Driver: one sample per transaction, with random gaps outside the calm phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                track_level(in_if.sample_byte);
            end
            if (!in_if.valid || in_if.ready) begin
                if (samples_todo.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
                    in_if.valid <= 1'b1;
                    in_if.sample_byte <= samples_todo.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every result transaction with the oldest expected span.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= 14);
            if (out_if.valid && out_if.ready) begin
                if (spans_due.size() == 0) begin
                    $error("unexpected result: duration_us %0d is_pulse %0b",
                           out_if.duration_us, out_if.is_pulse);
                    mismatches++;
                end else begin
                    want = spans_due.pop_front();
                    if (out_if.duration_us !== want.duration_us) begin
                        $error("duration_us: expected %0d, actual %0d",
                               want.duration_us, out_if.duration_us);
                        mismatches++;
                    end
                    if (out_if.is_pulse !== want.is_pulse) begin
                        $error("is_pulse: expected %0b, actual %0b",
                               want.is_pulse, out_if.is_pulse);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BAUD_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        if (idx == REG_PIN_SELECT) begin
            pin_now = data[PIN_W-1:0];
        end else if (idx == REG_BAUD_RATE) begin
            baud_now = data;
        end
    endtask

    task automatic program_regs(input logic [PIN_W-1:0] pin, input logic [BAUD_W-1:0] baud);
        write_reg(REG_PIN_SELECT,
                  {(BAUD_W - PIN_W)'($urandom_range((1 << (BAUD_W - PIN_W)) - 1)), pin});
        write_reg(REG_BAUD_RATE, baud);
        if ($urandom_range(1)) begin
            write_reg(REG_SPARE_A, BAUD_W'($urandom));
            write_reg(REG_SPARE_B, BAUD_W'($urandom));
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Samples that end no level leave no expectation behind, so allow the
    // pipeline some extra cycles once the last span has come out. The queues
    // are checked between edges, where the driver's updates have settled.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (samples_todo.size() > 0 || in_if.valid || spans_due.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_run(input logic level, input int len);
        logic [SAMPLE_W-1:0] smp;
        for (int k = 0; k < len; k++) begin
            smp = SAMPLE_W'($urandom_range(255));
            smp[pin_now] = level;
            samples_todo.push_back(smp);
        end
    endtask

    initial begin
        logic [BAUD_W-1:0] baud;
        logic              level;
        logic              slow_baud;
        int                queued;
        int                len;
        int                pick;

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_PIN_SELECT;
        cfg_data = '0;
        calm = 1'b0;
        in_if.valid = 1'b0;
        in_if.sample_byte = '0;
        out_if.ready = 1'b0;
        pin_now = PIN_RESET;
        baud_now = BAUD_RESET;
        held_level = 1'b0;
        level_seen = 1'b0;
        run_len = '0;
        mismatches = 0;
        quiet_cycles = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings. The first sample always reports, even at level low.
        samples_todo.push_back(8'h00);
        samples_todo.push_back(8'hFF);
        samples_todo.push_back(8'hFD);
        samples_todo.push_back(8'hFD);
        samples_todo.push_back(8'h02);
        samples_todo.push_back(8'h00);
        wait_quiet();

        // Baud rate 3000000: every short level rounds down to zero.
        program_regs(3'd7, 22'd3000000);
        samples_todo.push_back(8'h7F);
        samples_todo.push_back(8'h80);
        samples_todo.push_back(8'hFF);
        samples_todo.push_back(8'h00);
        wait_quiet();

        // Zero baud: the range check overflows and the duration clamps.
        program_regs(3'd0, 22'd0);
        samples_todo.push_back(8'h01);
        samples_todo.push_back(8'h00);
        samples_todo.push_back(8'h00);
        samples_todo.push_back(8'h01);
        wait_quiet();

        program_regs(3'd3, '1);
        samples_todo.push_back(8'h08);
        samples_todo.push_back(8'hF7);
        samples_todo.push_back(8'hF7);
        wait_quiet();

        // A saturated sample counter needs 2^32 samples and is out of reach here.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick = (ph == 0) ? 0 : $urandom_range(5);
            case (pick)
                0: baud = 22'd1;
                1: baud = 22'd3000000;
                2: baud = BAUD_W'($urandom_range(1, 3000000));
                3: baud = BAUD_W'($urandom_range(300, 115200));
                4: baud = $urandom_range(1) ? '0 : '1;
                default: baud = BAUD_W'($urandom);
            endcase
            slow_baud = (pick == 0);
            program_regs(PIN_W'($urandom_range(7)), baud);
            calm <= (ph == CALM_PHASE);
            level = 1'($urandom_range(1));
            queued = 0;
            while (queued < ((ph == CALM_PHASE) ? CALM_ITEMS : PHASE_ITEMS)) begin
                if (slow_baud && queued == 0) begin
                    // Long enough to overflow the 24-bit duration at one baud.
                    len = $urandom_range(540, 548);
                end else if ($urandom_range(99) < 70) begin
                    len = $urandom_range(1, 6);
                end else if ($urandom_range(99) < 95) begin
                    len = $urandom_range(7, 40);
                end else begin
                    len = $urandom_range(50, 120);
                end
                queue_run(level, len);
                queued += len;
                // Mostly alternate; sometimes repeat the level to merge runs.
                if (slow_baud || $urandom_range(99) >= 8) begin
                    level = ~level;
                end
            end
            // One more sample so that the last run is usually closed at this baud rate.
            queue_run(level, 1);
            wait_quiet();
            calm <= 1'b0;
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
